FILE: rtl/core/rv64ie_pkg.sv
// Shared types, codes and helpers for the RV64I execute unit.
`default_nettype none
package rv64ie_pkg;
	typedef enum logic [2:0] {
		ST_RETIRED  = 3'd0,
		ST_LOADREQ  = 3'd1,
		ST_STOREREQ = 3'd2,
		ST_ILLEGAL  = 3'd3,
		ST_FAULT    = 3'd4,
		ST_SEQERR   = 3'd5
	} status_t;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6f;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_FENCE  = 7'h0f;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_REGW   = 7'h3b;

	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [5:0] F6_SRAI = 6'h10;

	// Result of one item, as registered toward the output.
	typedef struct packed {
		status_t     status;
		logic [63:0] next_pc;
		logic [63:0] mem_addr;
		logic [1:0]  mem_size_log2;
		logic [63:0] mem_wdata;
		logic [4:0]  rd_index;
		logic [63:0] rd_value;
		logic        rd_written;
	} result_t;

	// Pending load bookkeeping, updated with each item.
	typedef struct packed {
		logic       pending;
		logic [4:0] dest;
		logic [1:0] size;
		logic       unsgn;
	} ld_state_t;

	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		unique case (sz)
			2'd0:    size_mask = 64'h0000_0000_0000_00ff;
			2'd1:    size_mask = 64'h0000_0000_0000_ffff;
			2'd2:    size_mask = 64'h0000_0000_ffff_ffff;
			default: size_mask = '1;
		endcase
	endfunction
endpackage
`default_nettype wire

FILE: rtl/core/rv64ie_regfile.sv
// 32 x 64 register file, two combinational reads, one write, x0 fixed zero.
`default_nettype none
module rv64ie_regfile (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [4:0]  ra,
	input  wire logic [4:0]  rb,
	output logic      [63:0] da,
	output logic      [63:0] db,
	input  wire logic        we,
	input  wire logic [4:0]  wa,
	input  wire logic [63:0] wd
);
	logic [63:0] regs_q [1:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < 32; i++) regs_q[i] <= '0;
		end else if (we && wa != 5'd0) begin
			regs_q[wa] <= wd;
		end
	end

	assign da = (ra == 5'd0) ? 64'd0 : regs_q[ra];
	assign db = (rb == 5'd0) ? 64'd0 : regs_q[rb];
endmodule
`default_nettype wire

FILE: rtl/core/rv64ie_exec.sv
// Decode and execute of one item: instruction or load return.
`default_nettype none
module rv64ie_exec (
	input  wire logic                  item_kind,
	input  wire logic [31:0]           instruction,
	input  wire logic [63:0]           load_data,
	input  wire logic                  load_ok,
	input  wire logic [63:0]           pc,
	input  wire rv64ie_pkg::ld_state_t ld,
	input  wire logic [63:0]           a,
	input  wire logic [63:0]           b,
	output rv64ie_pkg::result_t        res,
	output rv64ie_pkg::ld_state_t      ld_next
);
	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [5:0]  f6;
	logic [4:0]  rd;
	logic [63:0] immi, imms, immb, immj, immu, v, d, pc4;
	logic [5:0]  shi, shr;
	logic        ill, wr, take;
	logic        lts_ab, lts_ai;

	assign op   = instruction[6:0];
	assign f3   = instruction[14:12];
	assign f7   = instruction[31:25];
	assign f6   = instruction[31:26];
	assign rd   = instruction[11:7];
	assign immi = {{52{instruction[31]}}, instruction[31:20]};
	assign imms = {{52{instruction[31]}}, instruction[31:25], instruction[11:7]};
	assign immb = {{52{instruction[31]}}, instruction[7], instruction[30:25],
		instruction[11:8], 1'b0};
	assign immj = {{44{instruction[31]}}, instruction[19:12], instruction[20],
		instruction[30:21], 1'b0};
	assign immu = {{32{instruction[31]}}, instruction[31:12], 12'd0};
	assign shi  = instruction[25:20];
	assign shr  = b[5:0];
	assign pc4  = pc + 64'd4;
	assign lts_ab = $signed(a) < $signed(b);
	assign lts_ai = $signed(a) < $signed(immi);

	always_comb begin
		res     = '0;
		res.status  = rv64ie_pkg::ST_RETIRED;
		res.next_pc = pc;
		ld_next = ld;
		ill  = 1'b0;
		wr   = 1'b0;
		take = 1'b0;
		v    = '0;
		d    = '0;
		if (item_kind) begin
			if (!ld.pending) begin
				res.status = rv64ie_pkg::ST_SEQERR;
			end else if (load_ok) begin
				d = load_data & rv64ie_pkg::size_mask(ld.size);
				if (!ld.unsgn) begin
					case (ld.size)
						2'd0:    d = {{56{d[7]}}, d[7:0]};
						2'd1:    d = {{48{d[15]}}, d[15:0]};
						2'd2:    d = {{32{d[31]}}, d[31:0]};
						default: d = d;
					endcase
				end
				v  = d;
				wr = 1'b1;
				res.next_pc = pc4;
				ld_next.pending = 1'b0;
			end else begin
				res.status = rv64ie_pkg::ST_FAULT;
				ld_next.pending = 1'b0;
			end
			if (wr && ld.dest != 5'd0) begin
				res.rd_index   = ld.dest;
				res.rd_value   = v;
				res.rd_written = 1'b1;
			end
		end else if (ld.pending) begin
			res.status = rv64ie_pkg::ST_SEQERR;
		end else begin
			res.next_pc = pc4;
			unique case (op)
				rv64ie_pkg::OP_LUI: begin
					v = immu; wr = 1'b1;
				end
				rv64ie_pkg::OP_AUIPC: begin
					v = pc + immu; wr = 1'b1;
				end
				rv64ie_pkg::OP_JAL: begin
					v = pc4; wr = 1'b1; res.next_pc = pc + immj;
				end
				rv64ie_pkg::OP_JALR: begin
					if (f3 != 3'd0) ill = 1'b1;
					else begin
						v = pc4; wr = 1'b1;
						res.next_pc = (a + immi) & ~64'd1;
					end
				end
				rv64ie_pkg::OP_BRANCH: begin
					case (f3)
						3'd0:    take = (a == b);
						3'd1:    take = (a != b);
						3'd4:    take = lts_ab;
						3'd5:    take = !lts_ab;
						3'd7:    take = (a >= b);
						default: ill = 1'b1;
					endcase
					if (take) res.next_pc = pc + immb;
				end
				rv64ie_pkg::OP_LOAD: begin
					if (f3 == 3'd7) ill = 1'b1;
					else begin
						res.status        = rv64ie_pkg::ST_LOADREQ;
						res.mem_addr      = a + immi;
						res.mem_size_log2 = f3[1:0];
						res.next_pc       = pc;
						ld_next.pending   = 1'b1;
						ld_next.dest      = rd;
						ld_next.size      = f3[1:0];
						ld_next.unsgn     = f3[2];
					end
				end
				rv64ie_pkg::OP_STORE: begin
					if (f3[2]) ill = 1'b1;
					else begin
						res.status        = rv64ie_pkg::ST_STOREREQ;
						res.mem_addr      = a + imms;
						res.mem_size_log2 = f3[1:0];
						res.mem_wdata     = b & rv64ie_pkg::size_mask(f3[1:0]);
					end
				end
				rv64ie_pkg::OP_FENCE: begin
					if (f3 != 3'd0) ill = 1'b1;
				end
				rv64ie_pkg::OP_IMM: begin
					wr = 1'b1;
					case (f3)
						3'd0: v = a + immi;
						3'd1: if (f6 != 6'd0) ill = 1'b1; else v = a << shi;
						3'd2: v = {63'd0, lts_ai};
						3'd3: v = {63'd0, a < immi};
						3'd4: v = a ^ immi;
						3'd5: begin
							if (f6 == 6'd0) v = a >> shi;
							else if (f6 == rv64ie_pkg::F6_SRAI) v = $signed(a) >>> shi;
							else ill = 1'b1;
						end
						3'd6: v = a | immi;
						default: v = a & immi;
					endcase
				end
				rv64ie_pkg::OP_REG: begin
					wr = 1'b1;
					if (f7 == rv64ie_pkg::F7_ALT && f3 == 3'd5) v = $signed(a) >>> shr;
					else if (f7 != 7'd0) ill = 1'b1;
					else begin
						case (f3)
							3'd0:    v = a + b;
							3'd1:    v = a << shr;
							3'd2:    v = {63'd0, lts_ab};
							3'd4:    v = a ^ b;
							3'd5:    v = a >> shr;
							3'd6:    v = a | b;
							3'd7:    v = a & b;
							default: ill = 1'b1;
						endcase
					end
				end
				rv64ie_pkg::OP_REGW: begin
					if (f7 != 7'd0 || f3 != 3'd0) ill = 1'b1;
					else begin
						d  = a + b;
						v  = {{32{d[31]}}, d[31:0]};
						wr = 1'b1;
					end
				end
				default: ill = 1'b1;
			endcase
			if (ill) begin
				res = '0;
				res.status  = rv64ie_pkg::ST_ILLEGAL;
				res.next_pc = pc;
				ld_next     = ld;
				ld_next.pending = 1'b0;
			end else if (wr && rd != 5'd0) begin
				res.rd_index   = rd;
				res.rd_value   = v;
				res.rd_written = 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/rv64i_integer_execute_unit_core.sv
// Top level of the RV64I integer execute unit.
// Usage:
//  - Input channel (in_valid/in_stall): one beat is an instruction word
//    (item_kind 0) or the data of an outstanding load (item_kind 1).
//  - Output channel (out_valid/out_stall): exactly one result beat per input
//    beat, in order. status tells retire, load/store request, illegal,
//    load fault or sequence error.
//  - Config channel (cfg_valid/cfg_ready): write start_pc; it also reloads
//    the program counter. Write only while the unit is idle.
// Timing:
//  - An input beat is executed in the cycle it is accepted against the
//    register file and pc; the result is registered, so out_valid rises
//    in the cycle after acceptance.
//  - Throughput is one beat per cycle unless the receiver stalls; the
//    whole execute path (register read, one adder or shifter, writeback)
//    sits in front of the result register.
//  - While the receiver stalls, the result register holds and in_stall is
//    raised, so at most one result is buffered.
// Reset: register file, pc, start_pc and load tracking clear to zero and
// the output register empties.
`default_nettype none
module rv64i_integer_execute_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        item_kind,
	input  wire logic [31:0] instruction,
	input  wire logic [63:0] load_data,
	input  wire logic        load_ok,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [2:0]  status,
	output logic      [63:0] next_pc,
	output logic      [63:0] mem_addr,
	output logic      [1:0]  mem_size_log2,
	output logic      [63:0] mem_wdata,
	output logic      [4:0]  rd_index,
	output logic      [63:0] rd_value,
	output logic             rd_written,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data
);
	logic                  accept;
	logic [63:0]           pc_q;
	logic [63:0]           start_pc_q;
	rv64ie_pkg::ld_state_t ld_q, ld_next;
	rv64ie_pkg::result_t   res, res_s1;
	logic                  valid_s1;
	logic [63:0]           ra_data, rb_data;

	// Hold input while a result waits and the receiver stalls.
	assign in_stall  = valid_s1 && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	rv64ie_regfile u_rf (
		.clk   (clk),
		.arst_n(arst_n),
		.ra    (instruction[19:15]),
		.rb    (instruction[24:20]),
		.da    (ra_data),
		.db    (rb_data),
		.we    (accept && res.rd_written),
		.wa    (res.rd_index),
		.wd    (res.rd_value)
	);

	rv64ie_exec u_exec (
		.item_kind  (item_kind),
		.instruction(instruction),
		.load_data  (load_data),
		.load_ok    (load_ok),
		.pc         (pc_q),
		.ld         (ld_q),
		.a          (ra_data),
		.b          (rb_data),
		.res        (res),
		.ld_next    (ld_next)
	);

	// Architectural state: advance on accepted beats, reload pc on config.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			start_pc_q <= '0;
			ld_q       <= '0;
		end else begin
			if (accept) begin
				pc_q <= res.next_pc;
				ld_q <= ld_next;
			end
			if (cfg_valid && cfg_ready) begin
				start_pc_q <= cfg_data;
				pc_q       <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_s1 <= res;
	end

	assign out_valid     = valid_s1;
	assign status        = res_s1.status;
	assign next_pc       = res_s1.next_pc;
	assign mem_addr      = res_s1.mem_addr;
	assign mem_size_log2 = res_s1.mem_size_log2;
	assign mem_wdata     = res_s1.mem_wdata;
	assign rd_index      = res_s1.rd_index;
	assign rd_value      = res_s1.rd_value;
	assign rd_written    = res_s1.rd_written;

	// A held result must not change while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(res_s1))
		else $error("result changed under stall");
	// A load request leaves a load pending.
	a_ldreq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.status == rv64ie_pkg::ST_LOADREQ |=> ld_q.pending)
		else $error("load request did not set pending");
	// Writes never target x0.
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rd_written && rd_index == 5'd0))
		else $error("write to x0 reported");
	// Input is refused only while a result waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("stall without buffered result");
	unused_start: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_valid && cfg_ready && arst_n) |-> start_pc_q == $past(cfg_data))
		else $error("start_pc not captured");
endmodule
`default_nettype wire
